@@ rtl/ifhg_pkg.sv @@
// Shared types, constants and helper functions of the IPv4 fragment header generator.
// Used by the register write interface and by every module of the block; depends on nothing.
package ifhg_pkg;

	localparam int ACC_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MTU_W      = 14;

	localparam logic [15:0]      MAX_PAYLOAD = 16'd65515;
	localparam logic [MTU_W-1:0] MTU_MIN     = 14'd1048;
	localparam logic [MTU_W-1:0] MTU_MAX     = 14'd9000;
	localparam logic [MTU_W-1:0] HDR_LEN     = 14'd20;
	localparam logic [15:0]      VER_IHL_TOS = 16'h4500;
	localparam logic [7:0]       TTL_DEFAULT = 8'd64;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TOO_BIG = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_MTU    = 2'd3;

	typedef struct packed {
		logic [31:0] dest_ip;
		logic [7:0]  upper_protocol;
		logic [15:0] payload_length;
		logic        dont_fragment;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] next_hop_ip;
		logic [13:0] total_length;
		logic [15:0] identification;
		logic [15:0] flags_offset;
		logic [15:0] header_checksum;
		logic [15:0] payload_start;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0]      source_ip;
		logic [31:0]      subnet_mask;
		logic [31:0]      gateway_ip;
		logic [MTU_W-1:0] link_mtu;
	} cfg_regs_t;

	typedef struct packed {
		logic busy;
		logic load;
		logic id_adv;
	} seq_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM_SRC,
		S_SUM_DST,
		S_SINGLE,
		S_CALC,
		S_EMIT
	} seq_state_t;

	function automatic logic [MTU_W-1:0] clamp_mtu(input logic [MTU_W-1:0] mtu);
		logic [MTU_W-1:0] m;
		m = mtu;
		if (m < MTU_MIN) m = MTU_MIN;
		if (m > MTU_MAX) m = MTU_MAX;
		return m;
	endfunction

	// Fragment payload size: room after the header, rounded down to 8 bytes.
	function automatic logic [MTU_W-1:0] frag_size(input logic [MTU_W-1:0] mtu);
		logic [MTU_W-1:0] d;
		d = clamp_mtu(mtu) - HDR_LEN;
		return {d[MTU_W-1:3], 3'b000};
	endfunction

	// End-around carry fold of the header sum, then one's complement.
	function automatic logic [15:0] csum_fold(input logic [ACC_W-1:0] s);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = 17'(s[15:0]) + 17'(s[ACC_W-1:16]);
		f2 = 17'(f1[15:0]) + 17'(f1[16]);
		return ~f2[15:0];
	endfunction

endpackage

@@ rtl/ifhg_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload types come from ifhg_pkg at the instance.
interface ifhg_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/ifhg_cfg_if.sv @@
// Register write channel: valid/ready with a register index and write data.
// Depends on ifhg_pkg for the index and data widths.
interface ifhg_cfg_if import ifhg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/ifhg_csum_unit.sv @@
// Shared three-operand adder used for every header sum step, plus the checksum fold.
// Depends on ifhg_pkg.
module ifhg_csum_unit import ifhg_pkg::*; (
	input  logic [ACC_W-1:0] acc_in,
	input  logic [15:0]      op_a,
	input  logic [15:0]      op_b,
	output logic [ACC_W-1:0] sum_out,
	output logic [15:0]      csum_out
);

	assign sum_out  = acc_in + ACC_W'(op_a) + ACC_W'(op_b);
	assign csum_out = csum_fold(acc_in);

endmodule

@@ rtl/ifhg_seq.sv @@
// Sequencer and datapath: header sum setup, error checks and the fragment walk.
// Depends on ifhg_pkg and ifhg_csum_unit.
module ifhg_seq import ifhg_pkg::*; #(
	parameter int MAX_FRAGMENTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  in_item_t  in_item,
	input  cfg_regs_t cfg,
	input  logic      out_free,
	output out_item_t out_item,
	output seq_stat_t stat
);

	localparam int LIM_W = 16 + $clog2(MAX_FRAGMENTS + 1);

	seq_state_t state_q, state_d;

	logic [31:0]      dest_q;
	logic [15:0]      len_q;
	logic             df_q;
	logic [31:0]      hop_q;
	logic [MTU_W-1:0] psize_q;
	logic [LIM_W-1:0] limit_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] sum_q;
	logic             err_q;
	logic [15:0]      start_q;
	logic [15:0]      rem_q;
	logic [13:0]      tl_q;
	logic [15:0]      fo_q;
	logic             last_q;
	logic [15:0]      next_id_q;

	logic [ACC_W-1:0] acc_in;
	logic [15:0]      op_a;
	logic [15:0]      op_b;
	logic [ACC_W-1:0] sum_out;
	logic [15:0]      csum_out;

	logic [31:0] hop_c;
	logic        err_c;
	logic        last_c;
	logic [13:0] tl_c;
	logic [15:0] fo_c;

	ifhg_csum_unit u_csum (
		.acc_in   (acc_in),
		.op_a     (op_a),
		.op_b     (op_b),
		.sum_out  (sum_out),
		.csum_out (csum_out)
	);

	assign hop_c = (((cfg.source_ip ^ in_item.dest_ip) & cfg.subnet_mask) == 32'd0) ?
		in_item.dest_ip : cfg.gateway_ip;

	assign err_c = (len_q > MAX_PAYLOAD) || (df_q && (len_q > 16'(psize_q))) ||
		(LIM_W'(len_q) > limit_q);

	assign last_c = rem_q <= 16'(psize_q);
	assign tl_c   = last_c ? (rem_q[13:0] + HDR_LEN) : (psize_q + HDR_LEN);
	assign fo_c   = {1'b0, df_q & last_c, ~last_c, start_q[15:3]};

	// Operand selection for the shared adder.
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				acc_in = ACC_W'(VER_IHL_TOS);
				op_a   = {TTL_DEFAULT, in_item.upper_protocol};
				op_b   = next_id_q;
			end
			S_SUM_SRC: begin
				acc_in = acc_q;
				op_a   = cfg.source_ip[31:16];
				op_b   = cfg.source_ip[15:0];
			end
			S_SUM_DST: begin
				acc_in = acc_q;
				op_a   = dest_q[31:16];
				op_b   = dest_q[15:0];
			end
			S_CALC: begin
				acc_in = acc_q;
				op_a   = 16'(tl_c);
				op_b   = fo_c;
			end
			default: begin
				acc_in = sum_q;
				op_a   = 16'd0;
				op_b   = 16'd0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_SUM_SRC;
			end
			S_SUM_SRC: state_d = S_SUM_DST;
			S_SUM_DST: begin
				if (err_c || (len_q == 16'd0)) state_d = S_SINGLE;
				else state_d = S_CALC;
			end
			S_SINGLE: begin
				if (out_free) state_d = S_IDLE;
			end
			S_CALC: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) state_d = last_q ? S_IDLE : S_CALC;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		stat.busy   = state_q != S_IDLE;
		stat.load   = 1'b0;
		stat.id_adv = 1'b0;
		out_item.status          = ST_OK;
		out_item.next_hop_ip     = hop_q;
		out_item.total_length    = 14'd0;
		out_item.identification  = next_id_q;
		out_item.flags_offset    = 16'd0;
		out_item.header_checksum = 16'd0;
		out_item.payload_start   = 16'd0;
		out_item.last            = 1'b1;
		unique case (state_q)
			S_SINGLE: begin
				stat.load       = out_free;
				stat.id_adv     = out_free && !err_q;
				out_item.status = err_q ? ST_TOO_BIG : ST_EMPTY;
			end
			S_EMIT: begin
				stat.load                = out_free;
				stat.id_adv              = out_free && last_q;
				out_item.total_length    = tl_q;
				out_item.flags_offset    = fo_q;
				out_item.header_checksum = csum_out;
				out_item.payload_start   = start_q;
				out_item.last            = last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			next_id_q <= 16'd0;
		end else begin
			state_q <= state_d;
			if (stat.id_adv) next_id_q <= next_id_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					dest_q  <= in_item.dest_ip;
					len_q   <= in_item.payload_length;
					df_q    <= in_item.dont_fragment;
					hop_q   <= hop_c;
					psize_q <= frag_size(cfg.link_mtu);
					acc_q   <= sum_out;
				end
			end
			S_SUM_SRC: begin
				acc_q   <= sum_out;
				limit_q <= LIM_W'(MAX_FRAGMENTS) * LIM_W'(psize_q);
			end
			S_SUM_DST: begin
				acc_q   <= sum_out;
				err_q   <= err_c;
				start_q <= 16'd0;
				rem_q   <= len_q;
			end
			S_CALC: begin
				sum_q  <= sum_out;
				tl_q   <= tl_c;
				fo_q   <= fo_c;
				last_q <= last_c;
			end
			S_EMIT: begin
				if (out_free) begin
					start_q <= start_q + 16'(psize_q);
					rem_q   <= rem_q - 16'(psize_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/ipv4_fragment_header_generator_top.sv @@
// IPv4 fragment header generator, top level. An accepted request runs the sequencer through
// S_SUM_SRC and S_SUM_DST, then S_SINGLE for a single status result, or S_CALC and S_EMIT
// for each fragment; each result is loaded into the output register, and the block takes no
// new request until its last result is loaded. Reset clears the identification counter,
// empties the output register and loads the configuration defaults.
// Depends on ifhg_pkg, both interfaces, ifhg_seq and ifhg_csum_unit.
module ipv4_fragment_header_generator_top import ifhg_pkg::*; #(
	parameter int MAX_FRAGMENTS = 64
) (
	input logic         clk,
	input logic         arst_n,
	ifhg_stream_if.sink   seg_in,
	ifhg_stream_if.source frag_out,
	ifhg_cfg_if.sink      cfg
);

	// Configuration registers. Writes are always taken; the sequencer reads them live, safe
	// only if the user's software only writes while the block is idle; the block does not enforce it.
	cfg_regs_t cfg_q;

	// Output register holding one finished result until the sink takes it.
	logic      out_valid_q;
	out_item_t out_q;

	seq_stat_t stat;
	out_item_t seq_item;
	logic      in_fire;
	logic      out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_ip   <= 32'd0;
			cfg_q.subnet_mask <= 32'hFFFF_FF00;
			cfg_q.gateway_ip  <= 32'd0;
			cfg_q.link_mtu    <= 14'd1500;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SOURCE_IP:   cfg_q.source_ip   <= cfg.data;
				REG_SUBNET_MASK: cfg_q.subnet_mask <= cfg.data;
				REG_GATEWAY_IP:  cfg_q.gateway_ip  <= cfg.data;
				REG_LINK_MTU:    cfg_q.link_mtu    <= cfg.data[MTU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A new request is taken only when the sequencer is idle; a result that is
	// still waiting in the output register does not hold it back.
	assign seg_in.ready = !stat.busy;
	assign in_fire      = seg_in.valid && !stat.busy;

	// The sequencer may load a new result when the register is empty or is
	// being emptied in this cycle.
	assign out_free = !out_valid_q || frag_out.ready;

	ifhg_seq #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_item  (seg_in.data),
		.cfg      (cfg_q),
		.out_free (out_free),
		.out_item (seq_item),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.load) begin
			out_valid_q <= 1'b1;
		end else if (frag_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.load) out_q <= seq_item;
	end

	assign frag_out.valid = out_valid_q;
	assign frag_out.data  = out_q;

	// A load must never overwrite a result that the sink has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |-> (!out_valid_q || frag_out.ready))
		else $error("result register overwritten while still pending");

	// Error and empty-payload results always close their request.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |-> out_q.last)
		else $error("status result without last");

	// A real fragment carries a header plus payload and fits the link.
	a_frag_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == ST_OK)) |->
		((out_q.total_length > HDR_LEN) && (out_q.total_length <= clamp_mtu(cfg_q.link_mtu))))
		else $error("fragment length out of range");

	// An accepted request keeps the sequencer busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> stat.busy)
		else $error("sequencer not busy after accepting a request");

endmodule
